// File: design/cpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpat_pkg: shared types and constants
// Request kinds, table geometry and the per-cell control word.
// ----------------------------------------------------------------------------
package cpat_pkg;
  localparam int TableEntries = 32;
  localparam int NodeCount    = 64;
  localparam int IdW   = 29;
  localparam int NodeW = 6;
  localparam int CntW  = $clog2(TableEntries + 1);
  localparam int PosW  = $clog2(TableEntries);

  typedef enum logic [2:0] {
    K_REGISTER    = 3'd0,
    K_CHECKOUT    = 3'd1,
    K_ARBITRATE   = 3'd2,
    K_COMPLETE    = 3'd3,
    K_ERROR_FRAME = 3'd4,
    K_ERROR_DONE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_COMPACT, S_SCAN, S_MARK, S_OUT
  } state_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [NodeW-1:0] node;
    logic             remote;
    logic             valid;
    logic             marked;
  } entry_t;

  // Command to the whole row of cells
  typedef struct packed {
    logic           shift;      // every cell takes its right neighbour
    logic           load;       // load new entry at load_pos
    logic [PosW-1:0] load_pos;
    logic           drop;       // remove at drop_pos, shift tail left
    logic [PosW-1:0] drop_pos;
    logic           clr_marks;
    logic           mark;       // mark cells matching best per rule
    logic [IdW-1:0] best;
    logic [PosW-1:0] win;
  } cell_ctl_t;
endpackage

// File: design/can_priority_arbiter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_priority_arbiter_table: CAN transmit request table and arbiter
// Ordered request table as a row of cells with a scanning controller.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | kind, can_id, node, remote_request
// out_    | out | grant/flag result, one beat per request
// Register, checkout, error frame and unused kinds: the result beat is valid
// in the cycle after the request is taken. Arbitrate and error-done rotate
// the row once, comparing the cell at the head each cycle, then mark in S_MARK
// and register the result. Complete first compacts the row, dropping marked
// slots, then arbitrates. Reset clears the valid and mark bits and the control
// state. A result held on the output stalls the next request until taken, and
// an arbitration passes through S_OUT before the next request is taken.
// ----------------------------------------------------------------------------
module can_priority_arbiter_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind
  input  logic [39:0] in_tdata,   // can_id[28:0], node[34:29], remote_request[35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // grant_valid[0], grant_id[29:1], grant_node[35:30],
                                  // duplicate_id[36], bus_idle[37],
                                  // start_arbitration[38], overflow[39],
                                  // error_accepted[40]
);
  import cpat_pkg::*;

  entry_t    q   [TableEntries];
  entry_t    rgt [TableEntries];
  cell_ctl_t ctl;
  entry_t    load_e;
  logic [TableEntries-1:0] marked_v;

  state_t           st_r, st_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [PosW:0]    step_r, step_nxt;
  logic             idle_r, idle_nxt, err_r, err_nxt;
  logic [IdW-1:0]   best_r, best_nxt;
  logic [PosW-1:0]  win_r, win_nxt;
  logic [NodeW-1:0] wnode_r, wnode_nxt;
  logic             fdata_r, fdata_nxt;
  logic [1:0]       sends_r, sends_nxt;
  logic [47:0]      od_r, od_nxt;
  logic             ov_r, ov_nxt;

  logic [IdW-1:0]   i_id;
  logic [NodeW-1:0] i_node;
  logic             i_rtr;
  logic             hit;
  logic [PosW-1:0]  hit_pos;

  assign i_id   = in_tdata[28:0];
  assign i_node = in_tdata[34:29];
  assign i_rtr  = in_tdata[35];

  genvar g;
  generate
    for (g = 0; g < TableEntries; g++) begin : g_cell
      if (g == TableEntries - 1) begin : g_end
        // rotate during scan; tail takes empty when dropping
        assign rgt[g] = (st_r == S_SCAN) ? q[0] : '0;
      end else begin : g_mid
        assign rgt[g] = q[g+1];
      end
      assign marked_v[g] = q[g].marked;
      cpat_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .pos(PosW'(g)),
        .load_e(load_e), .right(rgt[g]), .q(q[g])
      );
    end
  endgenerate

  // first matching identifier for checkout
  always_comb begin
    hit = 1'b0;
    hit_pos = '0;
    for (int k = TableEntries - 1; k >= 0; k--)
      if (q[k].valid && q[k].id == i_id) begin
        hit = 1'b1;
        hit_pos = PosW'(k);
      end
  end

  assign load_e = '{id: i_id, node: i_node, remote: i_rtr, valid: 1'b1, marked: 1'b0};
  assign in_tready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; step_nxt = step_r;
    idle_nxt = idle_r; err_nxt = err_r; best_nxt = best_r; win_nxt = win_r;
    wnode_nxt = wnode_r; fdata_nxt = fdata_r; sends_nxt = sends_r;
    od_nxt = od_r; ov_nxt = ov_r;
    ctl = '0;
    ctl.best = best_r;
    ctl.win  = win_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          od_nxt = '0;
          unique case (in_tuser)
            K_REGISTER: begin
              if (cnt_r >= CntW'(TableEntries)) od_nxt[39] = 1'b1;
              else begin
                ctl.load = 1'b1;
                ctl.load_pos = cnt_r[PosW-1:0];
                cnt_nxt = cnt_r + 1'b1;
                if (idle_r) begin
                  idle_nxt = 1'b0;
                  od_nxt[38] = 1'b1;
                end
              end
              od_nxt[37] = (cnt_r < CntW'(TableEntries)) ? 1'b0 : idle_r;
              ov_nxt = 1'b1;
            end
            K_CHECKOUT: begin
              if (hit) begin
                ctl.drop = 1'b1;
                ctl.drop_pos = hit_pos;
                cnt_nxt = cnt_r - 1'b1;
              end
              od_nxt[37] = idle_r;
              ov_nxt = 1'b1;
            end
            K_ARBITRATE: begin
              step_nxt = '0;
              st_nxt = S_SCAN;
            end
            K_COMPLETE: begin
              err_nxt = 1'b0;
              step_nxt = '0;
              st_nxt = S_COMPACT;
            end
            K_ERROR_FRAME: begin
              if (!err_r) begin
                err_nxt = 1'b1;
                od_nxt[40] = 1'b1;
              end
              od_nxt[37] = idle_r;
              ov_nxt = 1'b1;
            end
            K_ERROR_DONE: begin
              ctl.clr_marks = 1'b1;
              err_nxt = 1'b0;
              step_nxt = '0;
              st_nxt = S_SCAN;
            end
            default: begin
              od_nxt[37] = idle_r;
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_COMPACT: begin
        // walk the occupied slots; drop a marked slot in place, else advance
        if (step_r >= cnt_r) begin
          step_nxt = '0;
          st_nxt = S_SCAN;
        end else if (marked_v[step_r[PosW-1:0]]) begin
          ctl.drop = 1'b1;
          ctl.drop_pos = step_r[PosW-1:0];
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SCAN: begin
        // rotate once; head holds entry step_r
        ctl.shift = 1'b1;
        if (q[0].valid) begin
          if (step_r == '0 || q[0].id < best_r) begin
            best_nxt = q[0].id;
            sends_nxt = q[0].remote ? 2'd0 : 2'd1;
            fdata_nxt = !q[0].remote;
            win_nxt = step_r[PosW-1:0];
            wnode_nxt = q[0].node;
          end else if (q[0].id == best_r && !q[0].remote) begin
            if (sends_r != 2'd2) sends_nxt = sends_r + 1'b1;
            if (!fdata_r) begin
              fdata_nxt = 1'b1;
              win_nxt = step_r[PosW-1:0];
              wnode_nxt = q[0].node;
            end
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == (PosW+1)'(TableEntries - 1)) st_nxt = S_MARK;
      end
      S_MARK: begin
        od_nxt = '0;
        if (cnt_r == '0) begin
          idle_nxt = 1'b1;
          od_nxt[37] = 1'b1;
        end else begin
          ctl.mark = 1'b1;
          od_nxt[0] = 1'b1;
          od_nxt[29:1] = best_r;
          od_nxt[35:30] = wnode_r;
          od_nxt[36] = (sends_r == 2'd2);
          od_nxt[37] = idle_r;
        end
        ov_nxt = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE && in_tvalid && in_tready && in_tuser == K_COMPLETE)
      ctl.clr_marks = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; idle_r <= 1'b1; err_r <= 1'b0; ov_r <= 1'b0;
      step_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; idle_r <= idle_nxt; err_r <= err_nxt;
      ov_r <= ov_nxt; step_r <= step_nxt;
    end
    best_r <= best_nxt; win_r <= win_nxt; wnode_r <= wnode_nxt;
    fdata_r <= fdata_nxt; sends_r <= sends_nxt; od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

// File: design/cpat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpat_cell: one table slot
// Holds one request; loads, shifts left, takes and clears marks as the row controller says.
// ----------------------------------------------------------------------------
module cpat_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  cpat_pkg::cell_ctl_t ctl,
  input  logic [cpat_pkg::PosW-1:0] pos,
  input  cpat_pkg::entry_t    load_e,
  input  cpat_pkg::entry_t    right,
  output cpat_pkg::entry_t    q
);
  import cpat_pkg::*;
  entry_t e_r, e_nxt;
  always_comb begin
    e_nxt = e_r;
    if (ctl.shift) e_nxt = right;
    else if (ctl.drop && pos >= ctl.drop_pos) e_nxt = right;
    else if (ctl.load && pos == ctl.load_pos) e_nxt = load_e;
    else begin
      if (ctl.clr_marks) e_nxt.marked = 1'b0;
      if (ctl.mark && e_r.valid && e_r.id == ctl.best && (e_r.remote || pos == ctl.win))
        e_nxt.marked = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid  <= 1'b0;
      e_r.marked <= 1'b0;
    end else begin
      e_r.valid  <= e_nxt.valid;
      e_r.marked <= e_nxt.marked;
    end
    e_r.id     <= e_nxt.id;
    e_r.node   <= e_nxt.node;
    e_r.remote <= e_nxt.remote;
  end
  assign q = e_r;
endmodule

// File: bench/can_priority_arbiter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_priority_arbiter_table_tb: request table and arbiter bench
// Drives register, checkout, arbitrate, complete and error requests, predicts
// every result beat from a behavioural copy of the table and compares it
// field by field, with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module can_priority_arbiter_table_tb;
  import cpat_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IdW-1:0]   can_id;
    logic [NodeW-1:0] node;
    logic             remote;
  } req_t;

  typedef struct packed {
    logic             grant_valid;
    logic [IdW-1:0]   grant_id;
    logic [NodeW-1:0] grant_node;
    logic             duplicate_id;
    logic             bus_idle;
    logic             start_arb;
    logic             overflow;
    logic             error_accepted;
  } grant_t;

  localparam int LIMIT = 3000000;
  localparam logic [2:0] K_UNUSED6 = 3'd6;
  localparam logic [2:0] K_UNUSED7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2:0] in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;

  can_priority_arbiter_table DUT (.*);

  always #5 clk = ~clk;

  // table model
  logic [IdW-1:0]   tbl_id     [TableEntries];
  logic [NodeW-1:0] tbl_node   [TableEntries];
  logic             tbl_remote [TableEntries];
  logic             tbl_marked [TableEntries];
  int               tbl_count = 0;
  logic             bus_idle_q = 1'b1;
  logic             err_latched = 1'b0;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     failures = 0;
  int     beats_out = 0;
  int     grants_seen = 0;
  int     cycles = 0;
  bit     stim_done = 1'b0;
  int     hold_off = 0;       // long receiver stall, counted down
  bit     hold_request = 1'b0;
  // accepted-at-posedge flag seen by the driver on the following falling edge
  logic   in_tready_q = 1'b0;

  task automatic add_req(input req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_id[i] = tbl_id[i+1];
      tbl_node[i] = tbl_node[i+1];
      tbl_remote[i] = tbl_remote[i+1];
      tbl_marked[i] = tbl_marked[i+1];
    end
    tbl_count--;
    tbl_marked[tbl_count] = 1'b0;
  endfunction

  function automatic void pick_winner(inout grant_t g);
    logic [IdW-1:0] best;
    int win;
    int sends;
    bit found;
    win = 0;
    sends = 0;
    found = 0;
    if (tbl_count == 0) begin
      bus_idle_q = 1'b1;
      return;
    end
    best = tbl_id[0];
    for (int i = 1; i < tbl_count; i++)
      if (tbl_id[i] < best) begin
        best = tbl_id[i];
        win = i;
      end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] != best) continue;
      if (!tbl_remote[i]) begin
        sends++;
        if (!found) begin
          found = 1;
          win = i;
          tbl_marked[i] = 1'b1;
        end
      end else begin
        tbl_marked[i] = 1'b1;
      end
    end
    g.grant_valid = 1'b1;
    g.grant_id = best;
    g.grant_node = tbl_node[win];
    g.duplicate_id = sends > 1;
  endfunction

  function automatic grant_t predict_grant(input req_t r);
    grant_t g;
    int j;
    g = '0;
    case (r.kind)
      K_REGISTER: begin
        if (tbl_count >= TableEntries) begin
          g.overflow = 1'b1;
        end else begin
          tbl_id[tbl_count] = r.can_id;
          tbl_node[tbl_count] = r.node;
          tbl_remote[tbl_count] = r.remote;
          tbl_marked[tbl_count] = 1'b0;
          tbl_count++;
          if (bus_idle_q) begin
            bus_idle_q = 1'b0;
            g.start_arb = 1'b1;
          end
        end
      end
      K_CHECKOUT: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_id[i] == r.can_id) begin
            drop_entry(i);
            break;
          end
      end
      K_ARBITRATE: pick_winner(g);
      K_COMPLETE: begin
        j = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_marked[i]) continue;
          tbl_id[j] = tbl_id[i];
          tbl_node[j] = tbl_node[i];
          tbl_remote[j] = tbl_remote[i];
          j++;
        end
        tbl_count = j;
        for (int i = 0; i < TableEntries; i++) tbl_marked[i] = 1'b0;
        err_latched = 1'b0;
        pick_winner(g);
      end
      K_ERROR_FRAME: begin
        if (!err_latched) begin
          err_latched = 1'b1;
          g.error_accepted = 1'b1;
        end
      end
      K_ERROR_DONE: begin
        for (int i = 0; i < TableEntries; i++) tbl_marked[i] = 1'b0;
        err_latched = 1'b0;
        pick_winner(g);
      end
      default: ;
    endcase
    g.bus_idle = bus_idle_q;
    return g;
  endfunction

  // ids drawn from a small pool so checkouts and duplicates hit
  function automatic req_t rand_req(input int wreg);
    req_t r;
    int sel;
    sel = $urandom_range(99);
    r.can_id = ($urandom_range(3) == 0) ? IdW'($urandom) : IdW'($urandom_range(15));
    r.node = NodeW'($urandom);
    r.remote = $urandom_range(3) == 0;
    if (sel < wreg) r.kind = K_REGISTER;
    else if (sel < wreg + 10) r.kind = K_CHECKOUT;
    else if (sel < wreg + 30) r.kind = K_ARBITRATE;
    else if (sel < wreg + 42) r.kind = K_COMPLETE;
    else if (sel < wreg + 48) r.kind = K_ERROR_FRAME;
    else if (sel < 99) r.kind = K_ERROR_DONE;
    else r.kind = $urandom_range(1) ? K_UNUSED6 : K_UNUSED7;
    return r;
  endfunction

  function automatic req_t mk(input logic [2:0] k, input logic [IdW-1:0] id,
                             input logic [NodeW-1:0] n, input logic rm);
    req_t r;
    r.kind = k;
    r.can_id = id;
    r.node = n;
    r.remote = rm;
    return r;
  endfunction

  initial begin
    // directed: extremes, remote-only winner, duplicates, errors, empty table
    add_req(mk(K_ARBITRATE, '0, '0, 1'b0));
    add_req(mk(K_REGISTER, '1, '1, 1'b1));
    add_req(mk(K_REGISTER, '0, '0, 1'b0));
    add_req(mk(K_REGISTER, 29'd5, 6'd1, 1'b1));
    add_req(mk(K_REGISTER, 29'd5, 6'd2, 1'b1));
    add_req(mk(K_CHECKOUT, '0, '0, 1'b0));
    add_req(mk(K_ARBITRATE, '0, '0, 1'b0));
    add_req(mk(K_ARBITRATE, '0, '0, 1'b0));
    add_req(mk(K_REGISTER, 29'd5, 6'd3, 1'b0));
    add_req(mk(K_REGISTER, 29'd5, 6'd4, 1'b0));
    add_req(mk(K_ERROR_FRAME, '0, '0, 1'b0));
    add_req(mk(K_ERROR_FRAME, '0, '0, 1'b0));
    add_req(mk(K_ERROR_DONE, '0, '0, 1'b0));
    add_req(mk(K_COMPLETE, '0, '0, 1'b0));
    add_req(mk(K_CHECKOUT, 29'd99, '0, 1'b0));
    add_req(mk(K_UNUSED6, '1, '1, 1'b1));
    add_req(mk(K_UNUSED7, '0, '0, 1'b0));
    for (int i = 0; i < 34; i++)
      add_req(mk(K_REGISTER, IdW'($urandom), NodeW'($urandom), i[0]));
    add_req(mk(K_COMPLETE, '0, '0, 1'b0));
    // random: phases that lean towards filling and towards draining
    for (int p = 0; p < 30; p++)
      for (int i = 0; i < 50; i++)
        add_req(rand_req(p[0] ? 60 : 25));
  end

  // driver
  int  gap = 0;
  req_t cur;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready_q)) begin
      // previous beat taken (or none offered)
      if (hold_request && expected_grants.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur = pending_reqs.pop_front();
        hold_request <= (pending_reqs.size() == 800);
        in_tvalid <= 1'b1;
        in_tuser <= cur.kind;
        in_tdata <= {4'b0, cur.remote, cur.node, cur.can_id};
        gap <= ($urandom_range(3) == 0) ? $urandom_range(14) : 0;
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_tready_q <= in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_grants = {expected_grants,
                         predict_grant({in_tuser, in_tdata[28:0], in_tdata[34:29],
                                        in_tdata[35]})};
  end

  // receiver back-pressure
  int stall = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      if (hold_off == 0) hold_off <= 300;
    end else if (pending_reqs.size() < 1300 && pending_reqs.size() > 1200 && hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready && $urandom_range(2) == 0) begin
        stall <= $urandom_range(14);
        out_tready <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t a;
    grant_t e;
    if (rst_n && out_tvalid && out_tready) begin
      a = {out_tdata[0], out_tdata[29:1], out_tdata[35:30], out_tdata[36],
           out_tdata[37], out_tdata[38], out_tdata[39], out_tdata[40]};
      beats_out <= beats_out + 1;
      if (a.grant_valid) grants_seen <= grants_seen + 1;
      if (expected_grants.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        failures <= failures + 1;
      end else begin
        e = expected_grants.pop_front();
        if (a.grant_valid !== e.grant_valid) begin
          $error("grant_valid: expected %0d actual %0d", e.grant_valid, a.grant_valid);
          failures <= failures + 1;
        end
        if (a.grant_id !== e.grant_id) begin
          $error("grant_id: expected %0h actual %0h", e.grant_id, a.grant_id);
          failures <= failures + 1;
        end
        if (a.grant_node !== e.grant_node) begin
          $error("grant_node: expected %0d actual %0d", e.grant_node, a.grant_node);
          failures <= failures + 1;
        end
        if (a.duplicate_id !== e.duplicate_id) begin
          $error("duplicate_id: expected %0d actual %0d", e.duplicate_id, a.duplicate_id);
          failures <= failures + 1;
        end
        if (a.bus_idle !== e.bus_idle) begin
          $error("bus_idle: expected %0d actual %0d", e.bus_idle, a.bus_idle);
          failures <= failures + 1;
        end
        if (a.start_arb !== e.start_arb) begin
          $error("start_arbitration: expected %0d actual %0d", e.start_arb, a.start_arb);
          failures <= failures + 1;
        end
        if (a.overflow !== e.overflow) begin
          $error("overflow: expected %0d actual %0d", e.overflow, a.overflow);
          failures <= failures + 1;
        end
        if (a.error_accepted !== e.error_accepted) begin
          $error("error_accepted: expected %0d actual %0d", e.error_accepted,
                 a.error_accepted);
          failures <= failures + 1;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    fork
      begin
        wait (stim_done && !in_tvalid && expected_grants.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d result beats checked, %0d of them grants, across fill, drain,",
                 beats_out, grants_seen);
        $display("overflow, duplicate, remote-only and error sequences");
        if (failures == 0 && expected_grants.size() == 0) begin
          $display("ALL CHECKS PASSED");
        end else begin
          $display("CHECKS FAILED");
        end
      end
      begin
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
      end
    join_any
    $finish;
  end
endmodule

// File: filelist.f
design/cpat_pkg.sv
design/cpat_cell.sv
design/can_priority_arbiter_table.sv
bench/can_priority_arbiter_table_tb.sv
